>>> hdl/hsv_to_rgb_converter_unit_assert.svh
// assertion macros shared by the hsv to rgb checker
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// checked only outside reset
`define HSV2RGB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define HSV2RGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/hsv2rgb_pkg.sv
// types, constants and sector decode for the hsv to rgb pipeline
package hsv2rgb_pkg;

  localparam int SECTOR_SPAN = 960;     // 60 degrees in 1/16 degree steps
  localparam int HUE_LIMIT   = 5760;    // 360 degrees
  localparam int NUM_SECTORS = 6;
  localparam int NUM_STAGES  = 5;
  localparam int SCALE_SHIFT = 30;      // 2^24 * 64, the power of two part of the divisor
  localparam int SAT_LIMIT   = 3840;    // 256 * 15
  localparam int RECIP_15    = 4370;    // ceil(2^16 / 15)
  localparam int RECIP_SHIFT = 16;

  typedef logic [12:0] hue_t;
  typedef logic [12:0] q12_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  sector_t;
  typedef logic [9:0]  ramp_fac_t;
  typedef logic [25:0] chroma_t;
  typedef logic [35:0] ramp_t;
  typedef logic signed [26:0] diff_t;
  typedef logic signed [37:0] sum_t;

  localparam sector_t SECTOR_GREY = 3'd6;

  typedef enum logic [1:0] {
    PART_ZERO,
    PART_CHROMA,
    PART_RAMP
  } part_sel_t;

  typedef struct packed {
    part_sel_t red;
    part_sel_t green;
    part_sel_t blue;
  } sel_set_t;

  // stage 2 -> mixer
  typedef struct packed {
    ramp_t    ramp;
    ramp_t    cpart;
    diff_t    diff;
    sel_set_t sel;
    byte_t    alpha;
  } mix_in_t;

  // mixer -> channel scalers
  typedef struct packed {
    sum_t  sum_red;
    sum_t  sum_green;
    sum_t  sum_blue;
    byte_t alpha;
  } chan_in_t;

  function automatic sel_set_t sector_sel(input sector_t sector);
    sel_set_t s;
    s = '{PART_ZERO, PART_ZERO, PART_ZERO};
    unique case (sector)
      3'd0: s = '{PART_CHROMA, PART_RAMP, PART_ZERO};
      3'd1: s = '{PART_RAMP, PART_CHROMA, PART_ZERO};
      3'd2: s = '{PART_ZERO, PART_CHROMA, PART_RAMP};
      3'd3: s = '{PART_ZERO, PART_RAMP, PART_CHROMA};
      3'd4: s = '{PART_RAMP, PART_ZERO, PART_CHROMA};
      3'd5: s = '{PART_CHROMA, PART_ZERO, PART_RAMP};
      default: s = '{PART_ZERO, PART_ZERO, PART_ZERO};
    endcase
    return s;
  endfunction

endpackage

>>> hdl/hsv2rgb_in_if.sv
// pixel input channel: hsv plus alpha
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
  logic  valid;
  logic  ready;
  hue_t  hue;
  q12_t  saturation;
  q12_t  brightness;
  byte_t alpha_in;

  modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
  modport sink (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

>>> hdl/hsv2rgb_out_if.sv
// pixel output channel: rgb plus alpha
interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t red;
  byte_t green;
  byte_t blue;
  byte_t alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink (input valid, red, green, blue, alpha_out, output ready);
endinterface

>>> hdl/hsv2rgb_chroma.sv
// stages 1 and 2: chroma, hue sector decode, ramp product and base difference
module hsv2rgb_chroma import hsv2rgb_pkg::*; (
  input  logic    clk,
  input  logic    en_a,
  input  logic    en_b,
  input  hue_t    hue,
  input  q12_t    saturation,
  input  q12_t    brightness,
  input  byte_t   alpha_in,
  output mix_in_t mix_out
);

  sector_t   sector;
  hue_t      offset;
  ramp_fac_t frac;
  ramp_fac_t ramp_fac;

  chroma_t   chroma_r;
  ramp_fac_t ramp_fac_r;
  q12_t      bright_r;
  sel_set_t  sel_r;
  byte_t     alpha_r;
  mix_in_t   mix_r;
  mix_in_t   mix_nxt;

  always_comb begin
    sector = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue >= 13'(k * SECTOR_SPAN)) begin
        sector = 3'(k);
      end
    end
    offset = hue - 13'(int'(sector) * SECTOR_SPAN);
    frac   = offset[9:0];
    // odd sectors ramp down
    ramp_fac = sector[0] ? (10'(SECTOR_SPAN) - frac) : frac;
    if (hue >= 13'(HUE_LIMIT)) begin
      sector = SECTOR_GREY;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      chroma_r   <= 26'(saturation) * 26'(brightness);
      ramp_fac_r <= ramp_fac;
      bright_r   <= brightness;
      sel_r      <= sector_sel(sector);
      alpha_r    <= alpha_in;
    end
  end

  always_comb begin
    mix_nxt.ramp  = 36'(chroma_r) * 36'(ramp_fac_r);
    mix_nxt.cpart = (36'(chroma_r) << 10) - (36'(chroma_r) << 6);
    mix_nxt.diff  = $signed({2'b00, bright_r, 12'b0}) - $signed({1'b0, chroma_r});
    mix_nxt.sel   = sel_r;
    mix_nxt.alpha = alpha_r;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      mix_r <= mix_nxt;
    end
  end

  assign mix_out = mix_r;

endmodule

>>> hdl/hsv2rgb_mix.sv
// stage 3: per channel sum of part and base in the common unit
module hsv2rgb_mix import hsv2rgb_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  mix_in_t  mix_in,
  output chan_in_t chan_out
);

  logic signed [36:0] diff_ext;
  logic signed [36:0] base;
  sum_t               base_ext;
  sum_t               part_red;
  sum_t               part_green;
  sum_t               part_blue;
  chan_in_t           chan_r;
  chan_in_t           chan_nxt;

  function automatic sum_t pick(input part_sel_t sel, input ramp_t ramp, input ramp_t cpart);
    sum_t p;
    case (sel)
      PART_CHROMA: p = $signed({2'b00, cpart});
      PART_RAMP:   p = $signed({2'b00, ramp});
      default:     p = '0;
    endcase
    return p;
  endfunction

  always_comb begin
    diff_ext   = 37'(mix_in.diff);
    // 960 * diff
    base       = (diff_ext <<< 10) - (diff_ext <<< 6);
    base_ext   = 38'(base);
    part_red   = pick(mix_in.sel.red, mix_in.ramp, mix_in.cpart);
    part_green = pick(mix_in.sel.green, mix_in.ramp, mix_in.cpart);
    part_blue  = pick(mix_in.sel.blue, mix_in.ramp, mix_in.cpart);
    chan_nxt.sum_red   = part_red + base_ext;
    chan_nxt.sum_green = part_green + base_ext;
    chan_nxt.sum_blue  = part_blue + base_ext;
    chan_nxt.alpha     = mix_in.alpha;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan_out = chan_r;

endmodule

>>> hdl/hsv2rgb_chan.sv
// stages 4 and 5: scale one channel sum by 255 / (960 * 2^24) and saturate
module hsv2rgb_chan import hsv2rgb_pkg::*; (
  input  logic  clk,
  input  logic  en_a,
  input  logic  en_b,
  input  sum_t  sum,
  output byte_t chan_byte
);

  logic signed [45:0] sum_ext;
  logic signed [45:0] scaled;
  logic signed [15:0] coarse;
  logic [11:0]        coarse_nxt;
  logic               sat_nxt;
  logic [11:0]        coarse_r;
  logic               sat_r;
  logic [24:0]        recip_prod;
  byte_t              byte_r;

  always_comb begin
    sum_ext = 46'(sum);
    scaled  = (sum_ext <<< 8) - sum_ext;
    // divide by 2^30 here, the remaining factor of 15 goes next stage
    coarse  = scaled[45:SCALE_SHIFT];
    coarse_nxt = '0;
    sat_nxt    = 1'b0;
    if (sum > 0) begin
      if (coarse >= 16'(SAT_LIMIT)) begin
        sat_nxt = 1'b1;
      end else begin
        coarse_nxt = coarse[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      coarse_r <= coarse_nxt;
      sat_r    <= sat_nxt;
    end
  end

  // floor(coarse / 15) by reciprocal, exact below the saturation limit
  assign recip_prod = 25'(coarse_r) * 25'(RECIP_15);

  always_ff @(posedge clk) begin
    if (en_b) begin
      byte_r <= sat_r ? 8'hFF : recip_prod[RECIP_SHIFT +: 8];
    end
  end

  assign chan_byte = byte_r;

endmodule

>>> hdl/hsv_to_rgb_converter_unit.sv
// hsv to rgb converter top level: five stage pipeline with per stage valid and stall
//
//   channel   direction  payload                                 handshake
//   in_pix    sink       hue, saturation, brightness, alpha_in   valid / ready
//   out_pix   source     red, green, blue, alpha_out             valid / ready
//
// one pixel per clock sustained while out_pix.ready is high; out_pix.valid rises when the
// input pixel reaches the last stage, after its valid bit has passed through every stage
// the five register stages are chroma/sector, ramp multiply, channel sum, scale, reciprocal
// a stage loads whenever it is empty or the stage after it moves, so bubbles close up
// under a stall nothing is lost; in_pix.ready drops only when all five stages hold pixels
// synchronous active low reset clears the valid bits only, no clearing pass
module hsv_to_rgb_converter_unit import hsv2rgb_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  hsv2rgb_in_if.sink    in_pix,
  hsv2rgb_out_if.source out_pix
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  mix_in_t  mix_in;
  chan_in_t chan_in;
  byte_t    alpha_d_r;
  byte_t    alpha_e_r;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_pix.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    vld_nxt[0] = en[0] ? in_pix.valid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  hsv2rgb_chroma u_chroma (
    .clk        (clk),
    .en_a       (en[0]),
    .en_b       (en[1]),
    .hue        (in_pix.hue),
    .saturation (in_pix.saturation),
    .brightness (in_pix.brightness),
    .alpha_in   (in_pix.alpha_in),
    .mix_out    (mix_in)
  );

  hsv2rgb_mix u_mix (
    .clk      (clk),
    .en       (en[2]),
    .mix_in   (mix_in),
    .chan_out (chan_in)
  );

  hsv2rgb_chan u_chan_red (
    .clk       (clk),
    .en_a      (en[3]),
    .en_b      (en[4]),
    .sum       (chan_in.sum_red),
    .chan_byte (out_pix.red)
  );

  hsv2rgb_chan u_chan_green (
    .clk       (clk),
    .en_a      (en[3]),
    .en_b      (en[4]),
    .sum       (chan_in.sum_green),
    .chan_byte (out_pix.green)
  );

  hsv2rgb_chan u_chan_blue (
    .clk       (clk),
    .en_a      (en[3]),
    .en_b      (en[4]),
    .sum       (chan_in.sum_blue),
    .chan_byte (out_pix.blue)
  );

  // alpha rides alongside the channel scalers
  always_ff @(posedge clk) begin
    if (en[3]) begin
      alpha_d_r <= chan_in.alpha;
    end
    if (en[4]) begin
      alpha_e_r <= alpha_d_r;
    end
  end

  assign in_pix.ready      = en[0];
  assign out_pix.valid     = vld_r[NUM_STAGES-1];
  assign out_pix.alpha_out = alpha_e_r;

endmodule

>>> hdl/hsv2rgb_checker.sv
// port level checker for the hsv to rgb converter, bound to the top level
`include "hsv_to_rgb_converter_unit_assert.svh"

module hsv2rgb_checker import hsv2rgb_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input byte_t red,
  input byte_t green,
  input byte_t blue,
  input byte_t alpha_out
);

  // reset empties the pipeline
  `HSV2RGB_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "out valid after reset")

  // an empty output stage means every stage can move
  `HSV2RGB_ASSERT(a_empty_ready, clk, rst_n, !out_valid |-> in_ready, "not ready while empty")

  // backpressure only comes from a stalled transaction at the output
  `HSV2RGB_ASSERT(a_ready_cause, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "spurious stall")

  `HSV2RGB_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha_out)), "stalled transaction changed")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .red       (out_pix.red),
  .green     (out_pix.green),
  .blue      (out_pix.blue),
  .alpha_out (out_pix.alpha_out)
);

>>> tb/hsv_to_rgb_converter_unit_tb.sv
// self-checking testbench for the hsv to rgb converter pipeline
`timescale 1ns / 100ps

module hsv_to_rgb_converter_unit_tb import hsv2rgb_pkg::*;;

  localparam int  CLK_HALF      = 6;
  localparam int  RESET_CYCLES  = 11;
  localparam int  TAIL_CYCLES   = 10;
  localparam int  MAX_REPORTS   = 10;
  localparam int  HOLD_CYCLES   = 60;
  localparam int  RANDOM_ITEMS  = 350;
  localparam int  Q12_ONE       = 4096;
  localparam int  BYTE_MAX      = 255;

  // hue sectors of 60 degrees each
  typedef enum int {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } hue_sector_e;

  typedef struct {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha;
  } rgb_pixel_t;

  logic clk;
  logic rst_n;
  bit   hold_off;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   error_count;

  rgb_pixel_t expected_rgb_q[$];

  hsv2rgb_in_if  in_pix();
  hsv2rgb_out_if out_pix();

  hsv_to_rgb_converter_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  always #(CLK_HALF) clk = ~clk;

  // exact floor of (part + base) * 255 over the common unit, clamped to a byte
  function automatic byte_t scale_channel(input longint part, input longint base);
    longint num;
    longint unit_den;
    longint q;
    unit_den = longint'(Q12_ONE) * Q12_ONE * SECTOR_SPAN;
    num      = (part + base) * BYTE_MAX;
    if (num <= 0) begin
      return '0;
    end
    q = num / unit_den;
    if (q > BYTE_MAX) begin
      q = BYTE_MAX;
    end
    return byte_t'(q);
  endfunction

  function automatic rgb_pixel_t predict_rgb(input hue_t hue, input q12_t sat,
                                             input q12_t bri, input byte_t alpha);
    rgb_pixel_t  px;
    longint      chroma;
    longint      cpart;
    longint      base;
    longint      ramp;
    longint      offs;
    longint      p_red;
    longint      p_green;
    longint      p_blue;
    hue_sector_e sector;
    chroma  = longint'(sat) * longint'(bri);
    cpart   = chroma * SECTOR_SPAN;
    base    = longint'(bri) * Q12_ONE * SECTOR_SPAN - cpart;
    p_red   = 0;
    p_green = 0;
    p_blue  = 0;
    if (hue < HUE_LIMIT) begin
      sector = hue_sector_e'(int'(hue) / SECTOR_SPAN);
      offs   = longint'(hue) - longint'(sector) * SECTOR_SPAN;
      // falling ramp in odd sectors, rising in even ones
      ramp   = (int'(sector) % 2 == 1) ? chroma * (SECTOR_SPAN - offs) : chroma * offs;
      case (sector)
        SEC_RED_YELLOW: begin
          p_red = cpart; p_green = ramp;
        end
        SEC_YELLOW_GREEN: begin
          p_red = ramp; p_green = cpart;
        end
        SEC_GREEN_CYAN: begin
          p_green = cpart; p_blue = ramp;
        end
        SEC_CYAN_BLUE: begin
          p_green = ramp; p_blue = cpart;
        end
        SEC_BLUE_MAGENTA: begin
          p_red = ramp; p_blue = cpart;
        end
        default: begin
          p_red = cpart; p_blue = ramp;
        end
      endcase
    end
    px.red   = scale_channel(p_red, base);
    px.green = scale_channel(p_green, base);
    px.blue  = scale_channel(p_blue, base);
    px.alpha = alpha;
    return px;
  endfunction

  // receiver: random stalls, plus a forced hold-off for back pressure
  always @(posedge clk) begin
    out_pix.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    rgb_pixel_t exp_px;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (expected_rgb_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected transaction: rgb %0d %0d %0d alpha %0d", out_pix.red,
                   out_pix.green, out_pix.blue, out_pix.alpha_out);
        end
      end else begin
        exp_px = expected_rgb_q.pop_front();
        if (out_pix.red !== exp_px.red || out_pix.green !== exp_px.green ||
            out_pix.blue !== exp_px.blue || out_pix.alpha_out !== exp_px.alpha) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected rgb %0d %0d %0d alpha %0d, got %0d %0d %0d %0d",
                     $realtime, exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                     out_pix.red, out_pix.green, out_pix.blue, out_pix.alpha_out);
          end
        end
      end
    end
  end

  task automatic send_pixel(input hue_t hue, input q12_t sat, input q12_t bri,
                            input byte_t alpha);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= hue;
    in_pix.saturation <= sat;
    in_pix.brightness <= bri;
    in_pix.alpha_in   <= alpha;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    expected_rgb_q.push_back(predict_rgb(hue, sat, bri, alpha));
  endtask

  function automatic q12_t pick_q12_level();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return q12_t'(0);
    end else if (pick < 10) begin
      return q12_t'(Q12_ONE);
    end else if (pick < 20) begin
      // over range: above one, with the 13th bit set
      return q12_t'($urandom_range(8191, Q12_ONE + 1));
    end
    return q12_t'($urandom_range(Q12_ONE));
  endfunction

  function automatic hue_t pick_hue();
    int pick;
    int sector;
    pick = $urandom_range(99);
    if (pick < 12) begin
      return hue_t'($urandom_range(8191, HUE_LIMIT));
    end else if (pick < 25) begin
      // near a sector boundary
      sector = $urandom_range(NUM_SECTORS - 1);
      return hue_t'(sector * SECTOR_SPAN + ($urandom_range(1) ? $urandom_range(2)
                                                              : SECTOR_SPAN - 1 - $urandom_range(2)));
    end
    return hue_t'($urandom_range(HUE_LIMIT - 1));
  endfunction

  task automatic send_random_pixel();
    send_pixel(pick_hue(), pick_q12_level(), pick_q12_level(), byte_t'($urandom_range(255)));
  endtask

  task automatic drain_pipeline();
    in_pix.valid <= 1'b0;
    do @(posedge clk); while (expected_rgb_q.size() != 0);
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    @(posedge clk);
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_pixel(13'd0,    13'd4096, 13'd4096, 8'd255);
    send_pixel(13'd959,  13'd4096, 13'd4096, 8'd0);
    send_pixel(13'd960,  13'd4096, 13'd4096, 8'h55);
    send_pixel(13'd1920, 13'd4096, 13'd4096, 8'hAA);
    send_pixel(13'd2880, 13'd4096, 13'd4096, 8'd1);
    send_pixel(13'd3840, 13'd4096, 13'd4096, 8'd128);
    send_pixel(13'd4800, 13'd4096, 13'd4096, 8'd254);
    send_pixel(13'd5759, 13'd4096, 13'd4096, 8'd7);
    send_pixel(13'd480,  13'd2048, 13'd2048, 8'd64);
    send_pixel(13'd1440, 13'd3000, 13'd3500, 8'd32);
    send_pixel(13'd4320, 13'd1234, 13'd4000, 8'd16);
    // hue at or past a full turn comes out grey
    send_pixel(13'd5760, 13'd2048, 13'd4096, 8'd200);
    send_pixel(13'd8191, 13'd8191, 13'd8191, 8'd255);
    send_pixel(13'd1000, 13'd0,    13'd4096, 8'd9);
    send_pixel(13'd1000, 13'd4096, 13'd0,    8'd10);
    send_pixel(13'd0,    13'd0,    13'd0,    8'd0);
    send_pixel(13'd1,    13'd1,    13'd1,    8'd11);
    // over range saturation or value: clamp high and low
    send_pixel(13'd0,    13'd8191, 13'd8191, 8'd12);
    send_pixel(13'd3000, 13'd8191, 13'd4096, 8'd13);
    send_pixel(13'd2000, 13'd0,    13'd8191, 8'd14);
    send_pixel(13'd5000, 13'd4097, 13'd4097, 8'd15);
    send_pixel(13'd2400, 13'd4096, 13'd8191, 8'd16);
    drain_pipeline();
  endtask

  task automatic test_random_streaming(input int idle_pct, input int stall_pct);
    set_idling(idle_pct, stall_pct);
    repeat (RANDOM_ITEMS) send_random_pixel();
    drain_pipeline();
  endtask

  task automatic test_back_pressure();
    set_idling(0, 0);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        repeat (40) send_random_pixel();
      end
    join
    drain_pipeline();
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    hold_off             = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    error_count          = 0;
    in_pix.valid         = 1'b0;
    in_pix.hue           = '0;
    in_pix.saturation    = '0;
    in_pix.brightness    = '0;
    in_pix.alpha_in      = '0;
    out_pix.ready        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_streaming(0, 0);
    test_random_streaming(53, 0);
    test_random_streaming(0, 53);
    test_random_streaming(24, 24);
    test_back_pressure();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rgb_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_in_if.sv
hdl/hsv2rgb_out_if.sv
hdl/hsv2rgb_chroma.sv
hdl/hsv2rgb_mix.sv
hdl/hsv2rgb_chan.sv
hdl/hsv_to_rgb_converter_unit.sv
hdl/hsv2rgb_checker.sv
tb/hsv_to_rgb_converter_unit_tb.sv
